@@ src/timestamp_ordered_event_queue_macros.svh @@
// Assertion macros for the timestamp-ordered event queue.
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TOEQ_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("event queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define TOEQ_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("event queue check failed");

`endif

@@ src/toeq_pkg.sv @@
// Shared types and constants of the timestamp-ordered event queue.
`default_nettype none

package toeq_pkg;

    localparam int TIME_W = 48;
    localparam int OBJ_W = 10;
    localparam int KIND_W = 8;
    localparam int PAY_W = 32;
    localparam int STATUS_W = 2;

    localparam int DEPTH_DEF = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELIVER = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_DELIVERED = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

endpackage

`default_nettype wire

@@ src/timestamp_ordered_event_queue.sv @@
// Top level of the timestamp-ordered pending-event queue.
// An insert into an empty or full queue, or a deliver from an empty one, strobes its result
// in the cycle after start; a deliver from a nonempty queue reads the head in S_POP, then strobes.
// An insert that steps past later events does one compare-and-move per cycle in S_SCAN, then
// writes the new event in place or in S_PLACE. One item at a time; busy holds while it works.
// Synchronous active-low reset empties the queue, not the store; the receiver cannot stall.
`default_nettype none

`include "timestamp_ordered_event_queue_macros.svh"

module timestamp_ordered_event_queue #(
    parameter int DEPTH = toeq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = toeq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cmd,
    input  wire logic [toeq_pkg::OBJ_W-1:0]    i_dest_object,
    input  wire logic [toeq_pkg::OBJ_W-1:0]    i_source_object,
    input  wire logic [toeq_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [toeq_pkg::TIME_W-1:0]   i_when,
    input  wire logic                          i_has_payload,
    input  wire logic [toeq_pkg::PAY_W-1:0]    i_payload,
    output logic                               o_done,
    output logic [toeq_pkg::STATUS_W-1:0]      o_status,
    output logic [toeq_pkg::OBJ_W-1:0]         o_out_dest_object,
    output logic [toeq_pkg::OBJ_W-1:0]         o_out_source_object,
    output logic [toeq_pkg::KIND_W-1:0]        o_out_kind,
    output logic [toeq_pkg::TIME_W-1:0]        o_out_when,
    output logic                               o_out_has_payload,
    output logic [toeq_pkg::PAY_W-1:0]         o_out_payload
);

    // Physical slot pointers wrap around a circular store; head is the earliest event.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    // Payload bits actually kept: never more than the port carries.
    localparam int SPW = (PAYLOAD_BITS < toeq_pkg::PAY_W) ? PAYLOAD_BITS : toeq_pkg::PAY_W;
    // Stored entry layout, MSB first: time, dest, source, kind, flag, payload.
    localparam int EW = toeq_pkg::TIME_W + 2 * toeq_pkg::OBJ_W + toeq_pkg::KIND_W + 1 + SPW;
    localparam int POS_FLAG = SPW;
    localparam int POS_KIND = SPW + 1;
    localparam int POS_SRC = POS_KIND + toeq_pkg::KIND_W;
    localparam int POS_DEST = POS_SRC + toeq_pkg::OBJ_W;
    localparam int POS_TIME = POS_DEST + toeq_pkg::OBJ_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_PLACE = 4'b0100,
        S_POP   = 4'b1000
    } t_state;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - AW'(1);
    endfunction

    // Control state.
    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic             r_done, n_done;

    // Work and result registers.
    logic [EW-1:0]    r_item, n_item;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]    r_left, n_left;
    toeq_pkg::t_status r_status, n_status;
    logic [EW-1:0]    r_res, n_res;

    // Store port signals.
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [EW-1:0]    w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [EW-1:0]    w_rdata;

    logic [EW-1:0]    w_new_entry;
    logic [SPW-1:0]   w_new_pay;
    logic             w_not_later;

    // Drop the payload word when the event carries none; keep only the stored bits.
    assign w_new_pay = i_has_payload ? i_payload[SPW-1:0] : '0;
    assign w_new_entry = {i_when, i_dest_object, i_source_object, i_kind,
                          i_has_payload, w_new_pay};

    // Scan compare: the stored event stays below the new one unless strictly later.
    assign w_not_later = (w_rdata[POS_TIME +: toeq_pkg::TIME_W]
                          <= r_item[POS_TIME +: toeq_pkg::TIME_W]);

    toeq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_done   = 1'b0;
        n_item   = r_item;
        n_rd_ptr = r_rd_ptr;
        n_left   = r_left;
        n_status = r_status;
        n_res    = r_res;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        w_wdata  = r_item;
        w_re     = 1'b0;
        w_raddr  = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == toeq_pkg::CMD_INSERT) begin
                        if (r_count == FULL_COUNT) begin
                            // Drop the event and flag the overflow.
                            n_done   = 1'b1;
                            n_status = toeq_pkg::ST_FULL;
                            n_res    = '0;
                        end else begin
                            n_count = r_count + CW'(1);
                            n_tail  = f_inc(r_tail);
                            n_item  = w_new_entry;
                            if (r_count == '0) begin
                                // Empty queue: the event lands at the tail directly.
                                w_we     = 1'b1;
                                w_waddr  = r_tail;
                                w_wdata  = w_new_entry;
                                n_done   = 1'b1;
                                n_status = toeq_pkg::ST_INSERTED;
                                n_res    = '0;
                            end else begin
                                // Start the scan at the latest stored event.
                                w_re     = 1'b1;
                                w_raddr  = f_dec(r_tail);
                                n_rd_ptr = f_dec(r_tail);
                                n_left   = AW'(r_count - CW'(1));
                                n_state  = S_SCAN;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_done   = 1'b1;
                            n_status = toeq_pkg::ST_EMPTY;
                            n_res    = '0;
                        end else begin
                            // Read the head and retire it right away.
                            w_re    = 1'b1;
                            w_raddr = r_head;
                            n_head  = f_inc(r_head);
                            n_count = r_count - CW'(1);
                            n_state = S_POP;
                        end
                    end
                end
            end

            S_SCAN: begin
                w_we    = 1'b1;
                w_waddr = f_inc(r_rd_ptr);
                if (w_not_later) begin
                    // Found the insertion point just above this event.
                    w_wdata  = r_item;
                    n_done   = 1'b1;
                    n_status = toeq_pkg::ST_INSERTED;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else begin
                    // Move the later event up one slot and keep scanning down.
                    w_wdata = w_rdata;
                    if (r_left == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        w_re     = 1'b1;
                        w_raddr  = f_dec(r_rd_ptr);
                        n_rd_ptr = f_dec(r_rd_ptr);
                        n_left   = r_left - AW'(1);
                    end
                end
            end

            S_PLACE: begin
                // Every stored event was later: fill the vacated head slot.
                w_we     = 1'b1;
                w_waddr  = r_rd_ptr;
                w_wdata  = r_item;
                n_done   = 1'b1;
                n_status = toeq_pkg::ST_INSERTED;
                n_res    = '0;
                n_state  = S_IDLE;
            end

            S_POP: begin
                n_done   = 1'b1;
                n_status = toeq_pkg::ST_DELIVERED;
                n_res    = w_rdata;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_rd_ptr <= n_rd_ptr;
        r_left   <= n_left;
        r_status <= n_status;
        r_res    <= n_res;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_out_when          = r_res[POS_TIME +: toeq_pkg::TIME_W];
    assign o_out_dest_object   = r_res[POS_DEST +: toeq_pkg::OBJ_W];
    assign o_out_source_object = r_res[POS_SRC +: toeq_pkg::OBJ_W];
    assign o_out_kind          = r_res[POS_KIND +: toeq_pkg::KIND_W];
    assign o_out_has_payload   = r_res[POS_FLAG];
    assign o_out_payload       = toeq_pkg::PAY_W'(r_res[SPW-1:0]);

    // An accepted item either strobes its result next cycle or keeps the block busy.
    `TOEQ_CHECK_NEXT(a_accept_progress, start && !busy, o_done || busy)
    // A result strobe only comes once the sequencer is back at rest.
    `TOEQ_CHECK_NOW(a_done_not_busy, o_done, !busy)
    // A scan only runs after at least one stored event plus the new one.
    `TOEQ_CHECK_NOW(a_scan_count, r_state == S_SCAN, r_count >= CW'(2) && r_count <= FULL_COUNT)

endmodule

`default_nettype wire

@@ src/toeq_ram.sv @@
// Simple dual-port event store: one write port, one registered read port.
`default_nettype none

module toeq_ram #(
    parameter int DEPTH = toeq_pkg::DEPTH_DEF,
    parameter int WIDTH = 8,
    parameter int AW = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
